// ===== hdl/icct_pkg.sv =====
// shared types and constants of the color temperature unit
package icct_pkg;

  // quotient width: 3810 * 65535 stays below 2^28
  localparam int unsigned DivBits = 28;
  localparam int unsigned ChanW   = 16;

  localparam logic [DivBits-1:0] SlopeK     = DivBits'(3810);
  localparam logic [ChanW-1:0]   OffsetK    = ChanW'(1391);
  localparam logic [8:0]         CycleBase  = 9'd256;
  localparam logic [8:0]         CycleLimit = 9'd63;
  localparam logic [ChanW-1:0]   DigitalSat = 16'hFFFF;
  localparam logic [7:0]         AtimeReset = 8'd255;

  // word handed from one divider cell to the next
  typedef struct packed {
    logic               reject;
    logic [ChanW-1:0]   divisor;
    logic [ChanW-1:0]   rem;
    logic [DivBits-1:0] nq;      // numerator bits still to shift out, quotient bits shifted in
  } div_word_t;

endpackage

// ===== hdl/icct_front.sv =====
// front stages: saturation check, ir removal and numerator product
module icct_front import icct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       integration_time_i,
  input  logic             valid_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  input  logic [ChanW-1:0] clear_count_i,
  output logic             valid_o,
  output div_word_t        word_o
);

  logic [8:0]       cycles;
  logic [ChanW-1:0] sat_level;
  logic             reject_a;
  logic [17:0]      sum_a;

  logic             valid_a_q, valid_b_q, valid_c_q;
  logic             reject_a_q, reject_b_q;
  logic [17:0]      sum_a_q;
  logic [ChanW-1:0] red_a_q, blue_a_q, clear_a_q;
  logic [ChanW-1:0] r2_b_q, b2_b_q;
  div_word_t        word_c_q;

  logic [18:0]      diff_b;
  logic [ChanW-1:0] ir_b;
  logic [ChanW-1:0] r2_b, b2_b;

  // saturation level: 768 counts per cycle below the digital limit
  assign cycles = CycleBase - {1'b0, integration_time_i};
  always_comb begin
    if (cycles > CycleLimit) begin
      sat_level = DigitalSat;
    end else begin
      sat_level = {1'b0, cycles[5:0], 9'd0} + {2'b00, cycles[5:0], 8'd0};
    end
  end

  assign reject_a = (clear_count_i == '0) || (clear_count_i >= sat_level);
  assign sum_a    = {2'b00, red_i} + {2'b00, green_i} + {2'b00, blue_i};

  // ir is half the excess of r+g+b over clear, kept to 16 bits
  assign diff_b = {1'b0, sum_a_q} - {3'b000, clear_a_q};
  assign ir_b   = (sum_a_q > {2'b00, clear_a_q}) ? diff_b[16:1] : '0;
  assign r2_b   = red_a_q - ir_b;
  assign b2_b   = blue_a_q - ir_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      reject_a_q       <= reject_a;
      sum_a_q          <= sum_a;
      red_a_q          <= red_i;
      blue_a_q         <= blue_i;
      clear_a_q        <= clear_count_i;
      reject_b_q       <= reject_a_q;
      r2_b_q           <= r2_b;
      b2_b_q           <= b2_b;
      word_c_q.reject  <= reject_b_q || (r2_b_q == '0);
      word_c_q.divisor <= r2_b_q;
      word_c_q.rem     <= '0;
      word_c_q.nq      <= SlopeK * {{(DivBits-ChanW){1'b0}}, b2_b_q};
    end
  end

  assign valid_o = valid_c_q;
  assign word_o  = word_c_q;

endmodule

// ===== hdl/icct_div_cell.sv =====
// one restoring divider cell: settles one quotient bit per pass
module icct_div_cell import icct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_word_t word_i,
  output logic      valid_o,
  output div_word_t word_o
);

  logic      [ChanW:0] rem_shift;
  logic                fits;
  div_word_t           word_d;
  logic                valid_q;
  div_word_t           word_q;

  assign rem_shift = {word_i.rem, word_i.nq[DivBits-1]};
  assign fits      = rem_shift >= {1'b0, word_i.divisor};

  always_comb begin
    word_d         = word_i;
    word_d.nq      = {word_i.nq[DivBits-2:0], fits};
    word_d.rem     = fits ? ChanW'(rem_shift - {1'b0, word_i.divisor})
                          : rem_shift[ChanW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== hdl/ir_compensated_color_temperature_unit.sv =====
// top level of the ir compensated color temperature unit
//
// input channel: in_valid_i / in_ready_o with red_i, green_i, blue_i and
//   clear_count_i, one raw sample per transaction
// output channel: out_valid_o / out_ready_i with kelvin_o, one result per
//   sample, in order; 0 marks a rejected sample (clear zero, clear at or
//   above saturation, or compensated red zero)
// config channel: cfg_valid_i / cfg_ready_o with cfg_data_i, the atime
//   value; always ready, write it only while no sample is in flight
// throughput: one sample per cycle while no result is held back, set by
//   the row of 28 divider cells that each settle one quotient bit and pass
//   the word on whenever the pipe advances; path to out_valid_o: 3 front
//   stages, 28 divider cells, 1 output register
// reset: pipeline emptied, atime returns to 255
// stall: while a result waits the pipe keeps moving until its last cell
//   holds a sample; only then does in_ready_o drop
module ir_compensated_color_temperature_unit import icct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  input  logic [ChanW-1:0] clear_count_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] kelvin_o
);

  logic [7:0]       atime_q;
  logic             en;
  logic             out_valid_q;
  logic [ChanW-1:0] kelvin_q;

  // cell chain taps: index 0 is the front output, DivBits the last cell
  logic             valid_c [DivBits+1];
  div_word_t        word_c  [DivBits+1];

  // config register, write any time the host asks
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atime_q <= AtimeReset;
    end else if (cfg_valid_i) begin
      atime_q <= cfg_data_i;
    end
  end

  // the whole pipe advances together; it may move whenever the output
  // register frees up or the last cell carries nothing to hand over
  assign en         = out_ready_i || !out_valid_q || !valid_c[DivBits];
  assign in_ready_o = en;

  icct_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .integration_time_i (atime_q),
    .valid_i            (in_valid_i),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .clear_count_i      (clear_count_i),
    .valid_o            (valid_c[0]),
    .word_o             (word_c[0])
  );

  // one cell per quotient bit, msb first
  for (genvar i = 0; i < DivBits; i++) begin : g_cell
    icct_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .word_i  (word_c[i]),
      .valid_o (valid_c[i+1]),
      .word_o  (word_c[i+1])
    );
  end

  // output register: offset added, rejected samples forced to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && valid_c[DivBits]) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_c[DivBits]) begin
      kelvin_q <= word_c[DivBits].reject ? '0
                                         : word_c[DivBits].nq[ChanW-1:0] + OffsetK;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kelvin_o    = kelvin_q;

  // input only blocks while a finished result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  // a sample leaving the last cell lands in the output register
  a_hand_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_c[DivBits] && en) |=> out_valid_o)
    else $error("result lost between last cell and output");

  // restoring division keeps the remainder below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_c[DivBits] && !word_c[DivBits].reject) |->
      (word_c[DivBits].rem < word_c[DivBits].divisor))
    else $error("divider remainder out of range");

endmodule
